### hdl/xbr_pkg.sv
// Package for the XOR basis range-max block: fixed field widths, stream
// packing offsets, command codes, sequencer states and the table control group.
// No dependencies.
package xbr_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 30;
    localparam int KEEP_W = 5;
    localparam int SIZE_W = 5;

    // Input tdata packing, lowest field first
    localparam int VALUE_LSB  = 0;
    localparam int KEEP_LSB   = VALUE_LSB + VAL_W;
    localparam int LOW_LSB    = KEEP_LSB + KEEP_W;
    localparam int HIGH_LSB   = LOW_LSB + VAL_W;
    localparam int S_TDATA_W  = ((HIGH_LSB + VAL_W + 7) / 8) * 8;

    // Output tdata packing: found, best, basis_size
    localparam int M_FIELDS_W = 1 + VAL_W + SIZE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_TRUNC  = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_LOAD,
        ST_ELIM,
        ST_GREEDY,
        ST_DONE
    } state_t;

    // Operations on the pivot table
    typedef struct packed {
        logic clr;
        logic load;
        logic elim;
    } tbl_ctrl_t;

endpackage

### hdl/xor_basis_range_max.sv
// Top level of the XOR basis range-max block: stream ports, sequencer, output
// register. Uses xbr_pkg, xbr_stack, xbr_table and xbr_alu.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  s_      | in  | value[29:0] keep_count[34:30]              | command[1:0]
//          |     | low_bound[64:35] high_bound[94:65] pad[95] |
//  m_      | out | found[0] best[30:1] basis_size[35:31]      | -
//          |     | pad[39:36]                                 |
//
// Insert reduces the value against each stored vector, reading the stack once
// per vector through the shared compare unit, then pushes a nonzero remainder.
// Truncate and unknown commands go straight to the final state.
// Query loads the pivot table from the stack, runs one elimination step per bit,
// then one greedy compare per bit.
// Reset (aresetn low, synchronous) empties the basis and the output register.
// The input is ready only in the idle state; a result still waiting on m_tready
// stalls the sequencer in its final state, and the next item waits until then.
module xor_basis_range_max
    import xbr_pkg::*;
#(
    parameter int VALUE_BITS = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value, keep_count, low_bound, high_bound
    input  logic [CMD_W-1:0]     s_tuser,  // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // found, best, basis_size
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    state_t                state_reg, state_next;
    cmd_t                  op_reg, op_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      b_reg, b_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [VALUE_BITS-1:0] lo_reg, lo_next;
    logic [VALUE_BITS-1:0] hi_reg, hi_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    cmd_t                  in_cmd;
    logic [VALUE_BITS-1:0] in_value;
    logic [KEEP_W-1:0]     in_keep;
    logic                  rd_issue;
    logic                  found;
    logic [VAL_W-1:0]      best;

    logic                  st_wr_en;
    logic                  st_rd_en;
    logic [VALUE_BITS-1:0] st_rd_data;

    tbl_ctrl_t             tbl_ctrl;
    logic [VALUE_BITS-1:0] tbl_rd_vec;
    logic                  tbl_rd_vld;

    logic [VALUE_BITS-1:0] alu_opnd;
    logic [VALUE_BITS-1:0] alu_lim;
    logic                  alu_incl;
    logic [VALUE_BITS-1:0] alu_res;
    logic                  alu_take;

    // Unpack the input item
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_value = VALUE_BITS'(s_tdata[VALUE_LSB +: VAL_W]);
    assign in_keep  = s_tdata[KEEP_LSB +: KEEP_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    xbr_stack #(.VALUE_BITS(VALUE_BITS)) u_stack (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (x_reg),
        .rd_en   (st_rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (st_rd_data)
    );

    xbr_table #(.VALUE_BITS(VALUE_BITS)) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tbl_ctrl),
        .idx     (b_reg),
        .din     (st_rd_data),
        .rd_vec  (tbl_rd_vec),
        .rd_vld  (tbl_rd_vld)
    );

    xbr_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
        .acc  (x_reg),
        .opnd (alu_opnd),
        .lim  (alu_lim),
        .incl (alu_incl),
        .res  (alu_res),
        .take (alu_take)
    );

    // In the final state the unit compares best against low_bound
    assign found = (op_reg == CMD_QUERY) && !alu_take;
    assign best  = (op_reg == CMD_QUERY) ? VAL_W'(x_reg) : '0;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        rd_idx_reg <= rd_idx_next;
        b_reg      <= b_next;
        x_reg      <= x_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        m_data_reg <= m_data_next;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = 1'b0;
        b_next       = b_reg;
        x_next       = x_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rd_issue     = 1'b0;
        st_rd_en     = 1'b0;
        st_wr_en     = 1'b0;
        tbl_ctrl     = '0;
        alu_opnd     = '0;
        alu_lim      = x_reg;
        alu_incl     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_cmd;
                    x_next      = in_value;
                    lo_next     = VALUE_BITS'(s_tdata[LOW_LSB +: VAL_W]);
                    hi_next     = VALUE_BITS'(s_tdata[HIGH_LSB +: VAL_W]);
                    rd_idx_next = '0;
                    case (in_cmd)
                        CMD_INSERT: begin
                            state_next = ST_INS;
                        end
                        CMD_TRUNC: begin
                            if (CMP_W'(in_keep) < CMP_W'(count_reg)) begin
                                count_next = CNT_W'(in_keep);
                            end
                            state_next = ST_DONE;
                        end
                        CMD_QUERY: begin
                            tbl_ctrl.clr = 1'b1;
                            state_next   = ST_LOAD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Reduce the value against each stored vector in stack order
            ST_INS: begin
                rd_issue  = (rd_idx_reg < count_reg);
                st_rd_en  = rd_issue;
                pend_next = rd_issue;
                if (rd_issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg) begin
                    alu_opnd = st_rd_data;
                    if (alu_take) begin
                        x_next = alu_res;
                    end
                end
                if (!rd_issue && !pend_reg) begin
                    if ((x_reg != '0) && (count_reg < CNT_W'(VALUE_BITS))) begin
                        st_wr_en   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end

            // Copy the stack into the pivot table
            ST_LOAD: begin
                rd_issue  = (rd_idx_reg < count_reg);
                st_rd_en  = rd_issue;
                pend_next = rd_issue;
                if (rd_issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg) begin
                    tbl_ctrl.load = 1'b1;
                end
                if (!rd_issue && !pend_reg) begin
                    b_next     = IDX_W'(VALUE_BITS - 1);
                    state_next = ST_ELIM;
                end
            end

            // Clear one pivot bit from all other rows, high pivot first
            ST_ELIM: begin
                tbl_ctrl.elim = 1'b1;
                if (b_reg == '0) begin
                    b_next     = IDX_W'(VALUE_BITS - 1);
                    x_next     = '0;
                    state_next = ST_GREEDY;
                end else begin
                    b_next = b_reg - 1'b1;
                end
            end

            // Greedy walk: take a row when the result stays within high_bound
            ST_GREEDY: begin
                alu_opnd = tbl_rd_vec;
                alu_lim  = hi_reg;
                alu_incl = 1'b1;
                if (tbl_rd_vld && alu_take) begin
                    x_next = alu_res;
                end
                if (b_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    b_next = b_reg - 1'b1;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                alu_lim = lo_reg;
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({SIZE_W'(count_reg), best, found});
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The basis never holds more vectors than there are bits
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(VALUE_BITS))
        else $error("basis count beyond VALUE_BITS");

    // A query leaves the stored basis alone
    a_query_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ELIM || state_reg == ST_GREEDY) |=> $stable(count_reg))
        else $error("basis count changed during query");

    // Truncate never grows the basis
    a_trunc_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_TRUNC) |=> count_reg <= $past(count_reg))
        else $error("truncate grew the basis");

    // An insert pushes at most one vector
    a_insert_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |=> (count_reg == $past(count_reg)
                                   || count_reg == $past(count_reg) + 1'b1))
        else $error("insert pushed more than one vector");

endmodule

### hdl/xbr_stack.sv
// Basis stack memory: one write port, one read port with registered data.
// Depends on nothing; sized by VALUE_BITS.
module xbr_stack #(
    parameter int VALUE_BITS = 30,
    localparam int IDX_W = $clog2(VALUE_BITS)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [VALUE_BITS];
    logic [VALUE_BITS-1:0] rd_data_reg;

    // Push a new vector
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/xbr_table.sv
// Pivot table for a query: one row per leading bit, built from the stack and
// brought to reduced echelon form one pivot per cycle. Uses xbr_pkg.
module xbr_table
    import xbr_pkg::*;
#(
    parameter int VALUE_BITS = 30,
    localparam int IDX_W = $clog2(VALUE_BITS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbl_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]      idx,
    input  logic [VALUE_BITS-1:0] din,
    output logic [VALUE_BITS-1:0] rd_vec,
    output logic                  rd_vld
);

    logic [VALUE_BITS-1:0] wt_reg [VALUE_BITS];
    logic [VALUE_BITS-1:0] wv_reg;
    logic [VALUE_BITS-1:0] pivot_vec;
    logic [IDX_W-1:0]      ld_idx;

    // Leading bit of the incoming vector picks its row
    always_comb begin
        ld_idx = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (din[i]) begin
                ld_idx = IDX_W'(i);
            end
        end
    end

    assign pivot_vec = wt_reg[idx];
    assign rd_vec    = pivot_vec;
    assign rd_vld    = wv_reg[idx];

    // Row occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= '0;
        end else if (ctrl.clr) begin
            wv_reg <= '0;
        end else if (ctrl.load) begin
            wv_reg[ld_idx] <= 1'b1;
        end
    end

    // Load a row, or clear the selected pivot bit from every other row
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            wt_reg[ld_idx] <= din;
        end else if (ctrl.elim && wv_reg[idx]) begin
            for (int e = 0; e < VALUE_BITS; e++) begin
                if ((IDX_W'(e) != idx) && wt_reg[e][idx]) begin
                    wt_reg[e] <= wt_reg[e] ^ pivot_vec;
                end
            end
        end
    end

endmodule

### hdl/xbr_alu.sv
// Shared XOR-and-compare unit: res = acc ^ opnd, take when res is below the
// limit (or equal, when incl is set). Depends on nothing.
module xbr_alu #(
    parameter int VALUE_BITS = 30
) (
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [VALUE_BITS-1:0] opnd,
    input  logic [VALUE_BITS-1:0] lim,
    input  logic                  incl,
    output logic [VALUE_BITS-1:0] res,
    output logic                  take
);

    assign res  = acc ^ opnd;
    assign take = incl ? (res <= lim) : (res < lim);

endmodule

### dv/tb_xor_basis_range_max.sv
// Self-checking testbench for xor_basis_range_max: insert, truncate and bounded-max query
// items go through the stream ports, and every result is checked against a local predictor.
// Depends on xbr_pkg and the xor_basis_range_max RTL.
module tb_xor_basis_range_max;
    timeunit 1ns;
    timeprecision 1ps;

    import xbr_pkg::*;

    // Command code that the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Result packing, lowest field first
    localparam int FOUND_BIT = 0;
    localparam int BEST_LSB  = 1;
    localparam int SIZE_LSB  = BEST_LSB + VAL_W;

    localparam int RANDOM_OPS = 1350;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [VAL_W-1:0]  value;
        logic [KEEP_W-1:0] keep;
        logic [VAL_W-1:0]  low;
        logic [VAL_W-1:0]  high;
        bit                drain;  // hold this item until no result is outstanding
    } basis_op_t;

    typedef struct {
        logic              found;
        logic [VAL_W-1:0]  best;
        logic [SIZE_W-1:0] size;
    } basis_result_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // value, keep_count, low_bound, high_bound, pad
    logic [CMD_W-1:0]     s_tuser  = '0;  // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // found, best, basis_size, pad

    basis_op_t     pending_ops[$];
    basis_result_t expected_results[$];
    logic          item_taken = 1'b0;
    int unsigned   fail_count = 0;
    int unsigned   op_count   = 0;

    // Predictor copy of the stored basis
    logic [VAL_W-1:0] span_vec [VAL_W];
    int unsigned      span_count = 0;

    // Sender and receiver pacing
    int       burst_left = 1;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_run     = 0;

    xor_basis_range_max #(
        .VALUE_BITS(VAL_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one command to the basis copy and return the result it must produce
    function automatic basis_result_t predict_basis_step(input basis_op_t op);
        logic [VAL_W-1:0] x, y, t, lead_mask, acc;
        logic [VAL_W-1:0] w [VAL_W];
        int               i, j, b;
        basis_result_t    r;
        r.found = 1'b0;
        r.best  = '0;
        if (op.cmd == CMD_INSERT) begin
            // reduce against the stack in order, push a nonzero remainder
            x = op.value;
            for (i = 0; i < span_count; i++) begin
                y = x ^ span_vec[i];
                if (y < x) x = y;
            end
            if (x != '0 && span_count < VAL_W) begin
                span_vec[span_count] = x;
                span_count++;
            end
        end else if (op.cmd == CMD_TRUNC) begin
            if (op.keep < span_count) span_count = op.keep;
        end else if (op.cmd == CMD_QUERY) begin
            for (i = 0; i < span_count; i++) w[i] = span_vec[i];
            // sort descending
            for (i = 1; i < span_count; i++) begin
                t = w[i];
                j = i;
                while (j > 0 && w[j-1] < t) begin
                    w[j] = w[j-1];
                    j--;
                end
                w[j] = t;
            end
            // clear each pivot bit from the rows above it
            for (i = 1; i < span_count; i++) begin
                lead_mask = '0;
                for (b = VAL_W - 1; b >= 0 && lead_mask == '0; b--) begin
                    if (w[i][b]) lead_mask[b] = 1'b1;
                end
                for (j = 0; j < i; j++) begin
                    if ((w[j] & lead_mask) != '0) w[j] = w[j] ^ w[i];
                end
            end
            // greedy walk from the top row down
            acc = '0;
            for (i = 0; i < span_count; i++) begin
                if ((acc ^ w[i]) <= op.high) acc = acc ^ w[i];
            end
            r.best  = acc;
            r.found = (acc >= op.low);
        end
        r.size = span_count[SIZE_W-1:0];
        return r;
    endfunction

    // Check results as they leave, then predict the item taken at this edge
    always @(posedge aclk) begin : check_results
        basis_op_t     seen;
        basis_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[FOUND_BIT] !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found,
                               m_tdata[FOUND_BIT]);
                        fail_count++;
                    end
                    if (m_tdata[BEST_LSB +: VAL_W] !== want.best) begin
                        $error("best: expected %h, actual %h", want.best,
                               m_tdata[BEST_LSB +: VAL_W]);
                        fail_count++;
                    end
                    if (m_tdata[SIZE_LSB +: SIZE_W] !== want.size) begin
                        $error("basis_size: expected %0d, actual %0d", want.size,
                               m_tdata[SIZE_LSB +: SIZE_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                seen.cmd   = s_tuser;
                seen.value = s_tdata[VALUE_LSB +: VAL_W];
                seen.keep  = s_tdata[KEEP_LSB +: KEEP_W];
                seen.low   = s_tdata[LOW_LSB +: VAL_W];
                seen.high  = s_tdata[HIGH_LSB +: VAL_W];
                seen.drain = 1'b0;
                want = predict_basis_step(seen);
                expected_results = {expected_results, want};
            end
        end
        item_taken <= aresetn && s_tvalid && s_tready;
    end

    // Feed items in bursts with random gaps; hold a marked item until results drain
    always @(negedge aclk) begin : drive_items
        logic                 next_valid;
        logic [S_TDATA_W-1:0] word;
        basis_op_t            op;
        next_valid = s_tvalid && !item_taken;
        if (aresetn && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].drain && expected_results.size() != 0)) begin
                op = pending_ops.pop_front();
                word = '0;
                word[VALUE_LSB +: VAL_W] = op.value;
                word[KEEP_LSB +: KEEP_W] = op.keep;
                word[LOW_LSB +: VAL_W]   = op.low;
                word[HIGH_LSB +: VAL_W]  = op.high;
                s_tdata <= word;
                s_tuser <= op.cmd;
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5:       gap_left = $urandom_range(1, 4);
                        6:          gap_left = $urandom_range(5, 40);
                        default:    gap_left = $urandom_range(41, 120);
                    endcase
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Receiver stalls: runs of always-ready, coin-flip and mostly-stalled
    always @(negedge aclk) begin : stall_pattern
        if (rx_run == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_run  = $urandom_range(16, 400);
        end
        rx_run--;
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [VAL_W-1:0] rand_magnitude();
        logic [VAL_W-1:0] r;
        r = VAL_W'($urandom());
        return r >> $urandom_range(0, VAL_W - 1);
    endfunction

    task automatic add_op(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                          input logic [KEEP_W-1:0] keep, input logic [VAL_W-1:0] low,
                          input logic [VAL_W-1:0] high, input bit drain);
        basis_op_t op;
        op.cmd   = cmd;
        op.value = value;
        op.keep  = keep;
        op.low   = low;
        op.high  = high;
        op.drain = drain;
        pending_ops = {pending_ops, op};
        if (cmd != CMD_UNUSED) op_count++;
    endtask

    task automatic add_query();
        logic [VAL_W-1:0] hi, lo;
        int               span;
        case ($urandom_range(0, 4))
            0: begin
                hi = '1;
                lo = rand_magnitude();
            end
            1: begin
                hi = rand_magnitude();
                lo = rand_magnitude();
            end
            2: begin
                hi   = rand_magnitude();
                span = $urandom_range(0, 64);
                lo   = (hi > span) ? hi - VAL_W'(span) : '0;
            end
            3: begin
                hi = VAL_W'($urandom_range(0, 255));
                lo = ($urandom_range(0, 3) == 0) ? '0 : VAL_W'($urandom_range(0, 255));
            end
            default: begin
                hi = rand_magnitude();
                lo = hi;
            end
        endcase
        add_op(CMD_QUERY, rand_magnitude(), KEEP_W'($urandom_range(0, 31)), lo, hi, 1'b0);
    endtask

    // Insert n vectors with distinct leading bits, mixing in dependent ones
    task automatic add_build(input int n, input bit drain);
        int               lead [VAL_W];
        int               i, k, tmp;
        logic [VAL_W-1:0] vec, top;
        logic [VAL_W-1:0] made[$];
        for (i = 0; i < VAL_W; i++) lead[i] = i;
        for (i = VAL_W - 1; i > 0; i--) begin
            k       = $urandom_range(0, i);
            tmp     = lead[i];
            lead[i] = lead[k];
            lead[k] = tmp;
        end
        for (i = 0; i < n; i++) begin
            top = VAL_W'(1) << lead[i];
            vec = top | (VAL_W'($urandom()) & (top - 1'b1));
            add_op(CMD_INSERT, vec, KEEP_W'($urandom_range(0, 31)), rand_magnitude(),
                   rand_magnitude(), drain && i == 0);
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                add_op(CMD_INSERT, vec ^ made[$urandom_range(0, i - 1)],
                       KEEP_W'($urandom_range(0, 31)), rand_magnitude(), rand_magnitude(),
                       1'b0);
            end
            made = {made, vec};
        end
    endtask

    initial begin : run_test
        int sel;

        // Empty basis queries
        add_op(CMD_QUERY, '0, '0, '0, '0, 1'b0);
        add_op(CMD_QUERY, '0, '0, 30'd1, '1, 1'b0);
        add_op(CMD_QUERY, '1, '1, '1, '1, 1'b0);
        // Zero, extremes, and a dependent insert
        add_op(CMD_INSERT, '0, '0, '0, '0, 1'b0);
        add_op(CMD_INSERT, '1, '0, '0, '0, 1'b0);
        add_op(CMD_INSERT, 30'd1, '0, '0, '0, 1'b0);
        add_op(CMD_INSERT, 30'h2000_0000, '0, '0, '0, 1'b0);
        add_op(CMD_INSERT, 30'h3FFF_FFFE, '0, '0, '0, 1'b0);
        // Full range, answer below the low bound, zero ceiling
        add_op(CMD_QUERY, '0, '0, '0, '1, 1'b0);
        add_op(CMD_QUERY, '0, '0, '1, 30'h1FFF_FFFF, 1'b0);
        add_op(CMD_QUERY, '0, '0, '0, '0, 1'b0);
        // Truncate above size, at the limit, and an ignored command
        add_op(CMD_TRUNC, '0, 5'd31, '0, '0, 1'b0);
        add_op(CMD_TRUNC, '0, 5'd30, '0, '0, 1'b0);
        add_op(CMD_UNUSED, '1, '1, '1, '1, 1'b0);
        add_op(CMD_TRUNC, '0, 5'd2, '0, '0, 1'b0);
        add_op(CMD_QUERY, '0, '0, 30'h155, 30'h2AAA_AAAA, 1'b0);
        add_op(CMD_TRUNC, '0, 5'd0, '0, '0, 1'b0);
        add_op(CMD_QUERY, '0, '0, '0, '1, 1'b0);
        add_op(CMD_INSERT, 30'h1555_5555, '0, '0, '0, 1'b0);
        add_op(CMD_INSERT, 30'h2AAA_AAAA, '0, '0, '0, 1'b0);
        add_op(CMD_QUERY, '0, '0, 30'h2AAA_AAAB, '1, 1'b0);

        // Fill the basis completely, then insert into the full basis
        add_op(CMD_TRUNC, rand_magnitude(), 5'd0, rand_magnitude(), rand_magnitude(), 1'b1);
        add_build(VAL_W, 1'b0);
        add_op(CMD_INSERT, rand_magnitude(), KEEP_W'($urandom_range(0, 31)), '0, '0, 1'b0);
        add_query();
        add_query();

        // Random part: mostly basis builds followed by queries
        sel = 0;
        while (op_count < RANDOM_OPS + 25) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                if ($urandom_range(0, 2) == 0) begin
                    add_op(CMD_TRUNC, rand_magnitude(), 5'd0, rand_magnitude(),
                           rand_magnitude(), 1'b0);
                end
                add_build(($urandom_range(0, 3) == 0) ? VAL_W : $urandom_range(1, 12),
                          $urandom_range(0, 7) == 0);
                repeat ($urandom_range(1, 4)) add_query();
            end else if (sel < 55) begin
                repeat ($urandom_range(1, 5)) add_query();
            end else if (sel < 68) begin
                add_op(CMD_TRUNC, rand_magnitude(), KEEP_W'($urandom_range(0, 31)),
                       rand_magnitude(), rand_magnitude(), 1'b0);
                add_query();
            end else if (sel < 80) begin
                add_op(CMD_INSERT, rand_magnitude(), KEEP_W'($urandom_range(0, 31)),
                       rand_magnitude(), rand_magnitude(), 1'b0);
            end else if (sel < 92) begin
                add_op(CMD_W'($urandom_range(0, 3)), rand_magnitude(),
                       KEEP_W'($urandom_range(0, 31)), rand_magnitude(), rand_magnitude(),
                       1'b0);
            end else begin
                add_op(CMD_UNUSED, rand_magnitude(), KEEP_W'($urandom_range(0, 31)),
                       rand_magnitude(), rand_magnitude(), 1'b0);
            end
        end

        // Release reset
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Drain, then let the longest operation finish
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (150) @(posedge aclk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hdl/xbr_pkg.sv
hdl/xbr_stack.sv
hdl/xbr_table.sv
hdl/xbr_alu.sv
hdl/xor_basis_range_max.sv
dv/tb_xor_basis_range_max.sv
